// ===== rtl/sbcr_pkg.sv =====
// package: shared constants and types for the sphere box collision resolver
package sbcr_pkg;
    localparam int MaxBoxesDefault     = 32;
    localparam int FractionBitsDefault = 16;
    localparam int StepTimeReset       = 1092;
    localparam int CfgWidth            = 24;

    localparam logic [0:0] OpLoad    = 1'b0;
    localparam logic [0:0] OpResolve = 1'b1;

    localparam logic [0:0] CfgBoxCount = 1'b0;
    localparam logic [0:0] CfgStepTime = 1'b1;

    localparam logic [0:0] KindContact = 1'b0;
    localparam logic [0:0] KindFinal   = 1'b1;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_pred,
        t_st_read,
        t_st_test,
        t_st_snap,
        t_st_out,
        t_st_final
    } t_state;

    typedef struct packed {
        logic       last;
        logic       report_kind;
        logic [4:0] hit_box;
        logic [5:0] contact_faces;
        logic       colliding;
        logic signed [31:0] out_centre_x;
        logic signed [31:0] out_centre_y;
        logic signed [31:0] out_centre_z;
        logic signed [31:0] out_speed_x;
        logic signed [31:0] out_speed_y;
        logic signed [31:0] out_speed_z;
    } t_result;

    typedef struct packed {
        logic [0:0] opcode;
        logic [4:0] box_index;
        logic [3:0] component;
        logic signed [31:0] load_value;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
        logic [30:0] radius;
        logic       has_gravity;
    } t_request;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage

// ===== rtl/sbcr_if.sv =====
// interface: valid/ready channel carrying one payload
interface sbcr_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sbcr_box_ram.sv =====
// box table memory: one row of six 32-bit words per box, word write, registered read
module sbcr_box_ram #(
    parameter int MAX_BOXES = sbcr_pkg::MaxBoxesDefault
) (
    input  logic i_clk,
    input  logic i_we,
    input  logic [$clog2(MAX_BOXES)-1:0] i_waddr,
    input  logic [2:0] i_wsel,
    input  logic signed [31:0] i_wdata,
    input  logic [$clog2(MAX_BOXES)-1:0] i_raddr,
    output logic [6*32-1:0] o_rdata
);
    logic [6*32-1:0] r_mem [MAX_BOXES];
    logic [6*32-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wsel*32 +: 32] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sphere_box_collision_resolver_core.sv =====
// top level: sphere versus box table collision resolver
// A resolve request visits n boxes, n being box_count limited to MAX_BOXES; a box hit adds
// an out state, and the out and final states wait while the consumer holds back a result:
// the prediction product is registered when the request is accepted and added in the next
// cycle, then one box row is fetched from the bounds and edge speed memories, tested and
// snapped in the read, test and snap states. Results leave through a single output register.
module sphere_box_collision_resolver_core #(
    parameter int MAX_BOXES     = sbcr_pkg::MaxBoxesDefault,
    parameter int FRACTION_BITS = sbcr_pkg::FractionBitsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [sbcr_pkg::CfgWidth-1:0] i_cfg_data,
    sbcr_if.sink   s_in,
    sbcr_if.source m_out
);
    localparam int Aw = $clog2(MAX_BOXES);
    localparam int Cw = $clog2(MAX_BOXES + 1);

    logic [5:0]  r_box_count;
    logic [23:0] r_step_time;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count <= '0;
            r_step_time <= 24'(sbcr_pkg::StepTimeReset);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbcr_pkg::CfgBoxCount: r_box_count <= i_cfg_data[5:0];
                sbcr_pkg::CfgStepTime: r_step_time <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    sbcr_pkg::t_state r_state, n_state;
    sbcr_pkg::t_request req;
    assign req = s_in.data;

    logic signed [31:0] r_c [3];
    logic signed [31:0] r_s [3];
    logic signed [56:0] r_prod [3];
    logic [30:0] r_rad;
    logic        r_grav;
    logic [Cw-1:0] r_nb;
    logic [Cw-1:0] r_b;
    logic [5:0]  r_sfaces;
    logic        r_any;
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic [5:0]  r_bfaces;
    sbcr_pkg::t_result r_out;
    logic        r_ov;

    logic [6*32-1:0] bnd_q, spd_q;
    logic ld_ok, we_b, we_s;
    assign ld_ok = s_in.valid && s_in.ready && req.opcode == sbcr_pkg::OpLoad
                   && 32'(req.box_index) < 32'(MAX_BOXES) && req.component < 4'd12;
    assign we_b = ld_ok && req.component < 4'd6;
    assign we_s = ld_ok && req.component >= 4'd6;
    logic [3:0] csub;
    assign csub = req.component - 4'd6;

    sbcr_box_ram #(.MAX_BOXES(MAX_BOXES)) u_bounds (
        .i_clk, .i_we(we_b), .i_waddr(req.box_index[Aw-1:0]),
        .i_wsel(req.component[2:0]), .i_wdata(req.load_value),
        .i_raddr(r_b[Aw-1:0]), .o_rdata(bnd_q));
    sbcr_box_ram #(.MAX_BOXES(MAX_BOXES)) u_speeds (
        .i_clk, .i_we(we_s), .i_waddr(req.box_index[Aw-1:0]),
        .i_wsel(csub[2:0]), .i_wdata(req.load_value),
        .i_raddr(r_b[Aw-1:0]), .o_rdata(spd_q));

    // axis choice from penetration depths
    logic signed [33:0] pen [3];
    logic [1:0] ax;
    logic signed [33:0] d_lo, d_hi;
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d_lo = 34'(r_c[a]) - 34'(r_lo[a]);
            d_hi = 34'(r_c[a]) - 34'(r_hi[a]);
            if (d_lo < 0) d_lo = -d_lo;
            if (d_hi < 0) d_hi = -d_hi;
            pen[a] = (d_lo < d_hi) ? d_lo : d_hi;
        end
        if (pen[0] < pen[1] && pen[0] < pen[2]) ax = 2'd0;
        else if (pen[1] < pen[2]) ax = 2'd1;
        else ax = 2'd2;
    end

    // centre inside the grown box on all three axes
    logic hit;
    assign hit = !(r_c[0] < r_lo[0] || r_c[0] > r_hi[0] || r_c[1] < r_lo[1]
                   || r_c[1] > r_hi[1] || r_c[2] < r_lo[2] || r_c[2] > r_hi[2]);

    logic signed [56:0] fl [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            fl[a] = r_prod[a] >>> FRACTION_BITS;
        end
    end

    logic out_free;
    assign out_free = !r_ov || m_out.ready;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
    assign s_in.ready  = (r_state == sbcr_pkg::t_st_idle);

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbcr_pkg::t_st_idle:
                if (s_in.valid && req.opcode == sbcr_pkg::OpResolve) n_state = sbcr_pkg::t_st_pred;
            sbcr_pkg::t_st_pred:
                n_state = (r_b < r_nb) ? sbcr_pkg::t_st_read : sbcr_pkg::t_st_final;
            sbcr_pkg::t_st_read: n_state = sbcr_pkg::t_st_test;
            sbcr_pkg::t_st_test: n_state = sbcr_pkg::t_st_snap;
            sbcr_pkg::t_st_snap:
                if (!hit) n_state = (r_b + 1'b1 < r_nb) ? sbcr_pkg::t_st_read
                                                       : sbcr_pkg::t_st_final;
                else n_state = sbcr_pkg::t_st_out;
            sbcr_pkg::t_st_out:
                if (out_free) n_state = (r_b + 1'b1 < r_nb) ? sbcr_pkg::t_st_read
                                                           : sbcr_pkg::t_st_final;
            sbcr_pkg::t_st_final:
                if (out_free) n_state = sbcr_pkg::t_st_idle;
            default: n_state = sbcr_pkg::t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbcr_pkg::t_st_idle;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && m_out.ready) r_ov <= 1'b0;
            if ((r_state == sbcr_pkg::t_st_out || r_state == sbcr_pkg::t_st_final) && out_free)
                r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sbcr_pkg::t_st_idle: begin
                r_c[0] <= req.centre_x; r_c[1] <= req.centre_y; r_c[2] <= req.centre_z;
                r_s[0] <= req.speed_x;  r_s[1] <= req.speed_y;  r_s[2] <= req.speed_z;
                r_prod[0] <= 57'(req.speed_x) * $signed({33'd0, r_step_time});
                r_prod[1] <= 57'(req.speed_y) * $signed({33'd0, r_step_time});
                r_prod[2] <= 57'(req.speed_z) * $signed({33'd0, r_step_time});
                r_rad <= req.radius;
                r_grav <= req.has_gravity;
                r_nb <= (32'(r_box_count) > 32'(MAX_BOXES)) ? Cw'(MAX_BOXES) : Cw'(r_box_count);
                r_b <= '0;
                r_sfaces <= '0;
                r_any <= 1'b0;
            end
            sbcr_pkg::t_st_pred: begin
                for (int a = 0; a < 3; a++) begin
                    r_c[a] <= sbcr_pkg::sat32(34'(r_c[a]) + 34'(
                        (fl[a] > 57'sd2147483647) ? 32'sh7fffffff :
                        (fl[a] < -57'sd2147483648) ? 32'sh80000000 : $signed(fl[a][31:0])));
                end
            end
            sbcr_pkg::t_st_test: begin
                for (int a = 0; a < 3; a++) begin
                    r_lo[a] <= sbcr_pkg::sat32(34'($signed(bnd_q[a*32 +: 32]))
                                               - 34'($signed({1'b0, r_rad})));
                    r_hi[a] <= sbcr_pkg::sat32(34'($signed(bnd_q[(a+3)*32 +: 32]))
                                               + 34'($signed({1'b0, r_rad})));
                end
            end
            sbcr_pkg::t_st_snap: begin
                if (hit) begin
                    r_any <= 1'b1;
                    if ((34'(r_c[ax]) <<< 1) < 34'(r_lo[ax]) + 34'(r_hi[ax])) begin
                        r_sfaces[{ax, 1'b0}] <= 1'b1;
                        r_bfaces <= 6'b1 << {ax, 1'b1};
                        r_c[ax] <= r_lo[ax];
                        if ($signed(spd_q[(32'(ax)+3)*32 +: 32]) < r_s[ax])
                            r_s[ax] <= $signed(spd_q[(32'(ax)+3)*32 +: 32]);
                    end else begin
                        r_sfaces[{ax, 1'b1}] <= 1'b1;
                        r_bfaces <= 6'b1 << {ax, 1'b0};
                        r_c[ax] <= r_hi[ax];
                        if ($signed(spd_q[32'(ax)*32 +: 32]) > r_s[ax])
                            r_s[ax] <= $signed(spd_q[32'(ax)*32 +: 32]);
                    end
                end else begin
                    r_b <= r_b + 1'b1;
                end
            end
            sbcr_pkg::t_st_out: begin
                if (out_free) begin
                    r_out.last <= 1'b0;
                    r_out.report_kind <= sbcr_pkg::KindContact;
                    r_out.hit_box <= 5'(r_b);
                    r_out.contact_faces <= r_bfaces;
                    r_out.colliding <= 1'b1;
                    r_out.out_centre_x <= r_c[0]; r_out.out_centre_y <= r_c[1];
                    r_out.out_centre_z <= r_c[2];
                    r_out.out_speed_x <= r_s[0]; r_out.out_speed_y <= r_s[1];
                    r_out.out_speed_z <= r_s[2];
                    r_b <= r_b + 1'b1;
                end
            end
            sbcr_pkg::t_st_final: begin
                if (out_free) begin
                    r_out.last <= 1'b1;
                    r_out.report_kind <= sbcr_pkg::KindFinal;
                    r_out.hit_box <= '0;
                    r_out.contact_faces <= r_sfaces;
                    r_out.colliding <= r_any;
                    r_out.out_centre_x <= r_c[0]; r_out.out_centre_y <= r_c[1];
                    r_out.out_centre_z <= r_c[2];
                    r_out.out_speed_x <= r_s[0];
                    r_out.out_speed_y <= (r_grav && r_sfaces[3] && r_s[1] < 0) ? '0 : r_s[1];
                    r_out.out_speed_z <= r_s[2];
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== verif/tb_top.sv =====
// testbench: directed and random checks of the sphere box collision resolver against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumBoxes = 32;
    localparam int FracBits = 16;
    localparam int LoadedBoxes = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = sbcr_pkg::CfgBoxCount;
    logic [sbcr_pkg::CfgWidth-1:0] i_cfg_data = '0;

    sbcr_if #(.t_payload(sbcr_pkg::t_request)) req_ch ();
    sbcr_if #(.t_payload(sbcr_pkg::t_result)) res_ch ();

    sphere_box_collision_resolver_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(req_ch.sink), .m_out(res_ch.source)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned boxes_used;
    longint unsigned frame_step;
    longint corner_pos [6*NumBoxes];
    longint corner_vel [6*NumBoxes];
    sbcr_pkg::t_result pending_results [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_frac(longint v);
        return v >>> FracBits;
    endfunction

    function automatic sbcr_pkg::t_result pack_result(bit lst, bit kind, int box, int faces,
                                                      bit coll, longint c[3], longint s[3]);
        sbcr_pkg::t_result r;
        r.last = lst;
        r.report_kind = kind;
        r.hit_box = box[4:0];
        r.contact_faces = faces[5:0];
        r.colliding = coll;
        r.out_centre_x = c[0][31:0];
        r.out_centre_y = c[1][31:0];
        r.out_centre_z = c[2][31:0];
        r.out_speed_x = s[0][31:0];
        r.out_speed_y = s[1][31:0];
        r.out_speed_z = s[2][31:0];
        return r;
    endfunction

    task automatic predict_contacts(input sbcr_pkg::t_request rq);
        longint c[3], s[3], sp[3], ct[3], lo[3], hi[3], pen[3], rad;
        int faces, bfaces, ax;
        bit any, hit;
        int unsigned nb;
        if (rq.opcode == sbcr_pkg::OpLoad) begin
            if (rq.component > 11) return;
            if (rq.component < 6) begin
                corner_pos[rq.box_index*6 + rq.component] = rq.load_value;
            end else begin
                corner_vel[rq.box_index*6 + rq.component - 6] = rq.load_value;
            end
            return;
        end
        faces = 0;
        any = 1'b0;
        rad = longint'(rq.radius);
        sp[0] = rq.speed_x; sp[1] = rq.speed_y; sp[2] = rq.speed_z;
        ct[0] = rq.centre_x; ct[1] = rq.centre_y; ct[2] = rq.centre_z;
        for (int a = 0; a < 3; a++) begin
            s[a] = sp[a];
            c[a] = clip32(ct[a] + clip32(floor_frac(sp[a] * longint'(frame_step))));
        end
        nb = boxes_used > NumBoxes ? NumBoxes : boxes_used;
        for (int b = 0; b < nb; b++) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++) begin
                lo[a] = clip32(corner_pos[b*6+a] - rad);
                hi[a] = clip32(corner_pos[b*6+3+a] + rad);
                if (!(c[a] >= lo[a] && c[a] <= hi[a])) hit = 1'b0;
            end
            if (!hit) continue;
            any = 1'b1;
            for (int a = 0; a < 3; a++) begin
                longint d1, d2;
                d1 = c[a] - lo[a]; if (d1 < 0) d1 = -d1;
                d2 = c[a] - hi[a]; if (d2 < 0) d2 = -d2;
                pen[a] = d1 < d2 ? d1 : d2;
            end
            if (pen[0] < pen[1] && pen[0] < pen[2]) ax = 0;
            else if (pen[1] < pen[2]) ax = 1;
            else ax = 2;
            if (2*c[ax] < lo[ax] + hi[ax]) begin
                faces |= 1 << (2*ax);
                bfaces = 1 << (2*ax+1);
                c[ax] = lo[ax];
                if (corner_vel[b*6+3+ax] < s[ax]) s[ax] = corner_vel[b*6+3+ax];
            end else begin
                faces |= 1 << (2*ax+1);
                bfaces = 1 << (2*ax);
                c[ax] = hi[ax];
                if (corner_vel[b*6+ax] > s[ax]) s[ax] = corner_vel[b*6+ax];
            end
            pending_results.push_back(pack_result(1'b0, sbcr_pkg::KindContact, b, bfaces,
                                                  1'b1, c, s));
        end
        if (rq.has_gravity && faces[3] && s[1] < 0) s[1] = 0;
        pending_results.push_back(pack_result(1'b1, sbcr_pkg::KindFinal, 0, faces, any, c, s));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // result checker, ready and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (req_ch.valid && req_ch.ready || res_ch.valid && res_ch.ready) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(res_ch.data.last), 0);
                end else begin
                    sbcr_pkg::t_result w, g;
                    w = pending_results.pop_front();
                    g = res_ch.data;
                    if (g.last !== w.last) report_mismatch("last", g.last, w.last);
                    if (g.report_kind !== w.report_kind)
                        report_mismatch("report_kind", g.report_kind, w.report_kind);
                    if (g.hit_box !== w.hit_box) report_mismatch("hit_box", g.hit_box, w.hit_box);
                    if (g.contact_faces !== w.contact_faces)
                        report_mismatch("contact_faces", g.contact_faces, w.contact_faces);
                    if (g.colliding !== w.colliding)
                        report_mismatch("colliding", g.colliding, w.colliding);
                    if (g.out_centre_x !== w.out_centre_x)
                        report_mismatch("out_centre_x", g.out_centre_x, w.out_centre_x);
                    if (g.out_centre_y !== w.out_centre_y)
                        report_mismatch("out_centre_y", g.out_centre_y, w.out_centre_y);
                    if (g.out_centre_z !== w.out_centre_z)
                        report_mismatch("out_centre_z", g.out_centre_z, w.out_centre_z);
                    if (g.out_speed_x !== w.out_speed_x)
                        report_mismatch("out_speed_x", g.out_speed_x, w.out_speed_x);
                    if (g.out_speed_y !== w.out_speed_y)
                        report_mismatch("out_speed_y", g.out_speed_y, w.out_speed_y);
                    if (g.out_speed_z !== w.out_speed_z)
                        report_mismatch("out_speed_z", g.out_speed_z, w.out_speed_z);
                end
            end
            if (quiet_cycles > 20000) begin
                $display("sphere_box_collision_resolver_core: mismatch");
                $finish;
            end
        end
    end

    // valid stays high between requests sent back to back
    task automatic send_request(input sbcr_pkg::t_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_contacts(rq);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input int unsigned value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[sbcr_pkg::CfgWidth-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sbcr_pkg::CfgBoxCount) boxes_used = value & 63;
        else frame_step = value & 24'hffffff;
        @(posedge i_clk);
    endtask

    function automatic sbcr_pkg::t_request rand_request();
        sbcr_pkg::t_request rq;
        rq = '0;
        rq.centre_x = $urandom; rq.centre_y = $urandom; rq.centre_z = $urandom;
        rq.speed_x = $urandom; rq.speed_y = $urandom; rq.speed_z = $urandom;
        rq.radius = $urandom; rq.has_gravity = $urandom;
        rq.box_index = $urandom; rq.component = $urandom; rq.load_value = $urandom;
        return rq;
    endfunction

    // scene near origin so hits are frequent
    function automatic sbcr_pkg::t_request near_sphere();
        sbcr_pkg::t_request rq;
        rq = rand_request();
        rq.opcode = sbcr_pkg::OpResolve;
        rq.centre_x = $signed($urandom_range(32'h80000)) - 32'sh40000;
        rq.centre_y = $signed($urandom_range(32'h80000)) - 32'sh40000;
        rq.centre_z = $signed($urandom_range(32'h80000)) - 32'sh40000;
        rq.speed_x = $signed($urandom_range(32'h100000)) - 32'sh80000;
        rq.speed_y = $signed($urandom_range(32'h100000)) - 32'sh80000;
        rq.speed_z = $signed($urandom_range(32'h100000)) - 32'sh80000;
        rq.radius = $urandom_range(32'h20000);
        return rq;
    endfunction

    task automatic load_component(input int box, input int comp, input int value);
        sbcr_pkg::t_request rq;
        rq = rand_request();
        rq.opcode = sbcr_pkg::OpLoad;
        rq.box_index = box;
        rq.component = comp;
        rq.load_value = value;
        send_request(rq);
    endtask

    task automatic load_random_box(input int box);
        int lo;
        for (int a = 0; a < 3; a++) begin
            lo = $signed($urandom_range(32'h60000)) - 32'sh30000;
            load_component(box, a, lo);
            load_component(box, 3 + a, lo + $signed($urandom_range(32'h30000)) - 32'sh4000);
            load_component(box, 6 + a, $urandom);
            load_component(box, 9 + a, $urandom);
        end
    endtask

    task automatic test_directed();
        sbcr_pkg::t_request rq;
        for (int b = 0; b < 3; b++) load_random_box(b);
        load_component(0, 3, 32'sh7fffffff);
        load_component(0, 4, 32'sh7fffffff);
        load_component(1, 0, 32'sh80000000);
        load_component(0, 12, 32'sh1234);
        load_component(0, 15, 32'sh1234);
        write_register(sbcr_pkg::CfgBoxCount, 3);
        rq = near_sphere();
        rq.has_gravity = 1'b1;
        send_request(rq);
        rq.centre_x = 32'sh7fffffff; rq.centre_y = 32'sh80000000;
        rq.speed_x = 32'sh7fffffff; rq.speed_y = 32'sh80000000;
        rq.radius = 31'h7fffffff;
        send_request(rq);
        rq.radius = 0; rq.has_gravity = 1'b0;
        send_request(rq);
        write_register(sbcr_pkg::CfgStepTime, 24'hffffff);
        send_request(near_sphere());
        write_register(sbcr_pkg::CfgStepTime, 0);
        send_request(near_sphere());
        write_register(sbcr_pkg::CfgBoxCount, 0);
        send_request(near_sphere());
    endtask

    task automatic test_random();
        sbcr_pkg::t_request rq;
        int n;
        for (int b = 3; b < LoadedBoxes; b++) load_random_box(b);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 22 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 22 : 0;
            write_register(sbcr_pkg::CfgBoxCount,
                           ph == 0 ? LoadedBoxes : $urandom_range(0, LoadedBoxes));
            write_register(sbcr_pkg::CfgStepTime, ph == 0 ? 1092 : $urandom_range(0, 24'h20000));
            n = 0;
            while (n < 35) begin
                if ($urandom_range(9) < 7) begin
                    send_request(near_sphere());
                end else if ($urandom_range(1)) begin
                    rq = rand_request();
                    rq.opcode = sbcr_pkg::OpResolve;
                    send_request(rq);
                end else begin
                    rq = rand_request();
                    rq.opcode = sbcr_pkg::OpLoad;
                    send_request(rq);
                end
                n++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 6*NumBoxes; i++) begin
            corner_pos[i] = 0;
            corner_vel[i] = 0;
        end
        boxes_used = 0;
        frame_step = sbcr_pkg::StepTimeReset;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain_results();
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("sphere_box_collision_resolver_core: match");
        end else begin
            $display("sphere_box_collision_resolver_core: mismatch");
        end
        $finish;
    end
endmodule

// ===== sphere_box_collision_resolver_core.f =====
rtl/sbcr_pkg.sv
rtl/sbcr_if.sv
rtl/sbcr_box_ram.sv
rtl/sphere_box_collision_resolver_core.sv
verif/tb_top.sv
